// ===== rtl/core/fractional_sinc_fir_resampler_assert.svh =====
// Assertion macros for the fractional resampler.
`ifndef FRACTIONAL_SINC_FIR_RESAMPLER_ASSERT_SVH
`define FRACTIONAL_SINC_FIR_RESAMPLER_ASSERT_SVH

// same-cycle implication, clocked on clk, off in reset
`define FSFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsfr assertion failed");

// next-cycle implication, clocked on clk, off in reset
`define FSFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsfr assertion failed");

`endif

// ===== rtl/core/fsfr_pkg.sv =====
// Shared constants, codes and types of the fractional resampler.
package fsfr_pkg;

  localparam int TAPS        = 23;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_W      = 21;
  localparam int IDX_W       = 5;
  localparam int TAP_W       = $clog2(TAPS);
  localparam int SEEN_W      = $clog2(TAPS + 1);
  localparam int MAX_OUT     = 4;
  localparam int OCNT_W      = $clog2(MAX_OUT + 1);
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = PROD_W + $clog2(TAPS);
  localparam int PHASE_W     = STEP_W + 3;
  localparam int STEP_MIN    = 16384;
  localparam int RATE_RESET  = 196608;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic REG_RATE = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [TAP_W-1:0]              idx;
    logic signed [COEF_BITS-1:0]   coef;
  } cmd_t;

  typedef struct packed {
    logic [OCNT_W-1:0] out_cnt;
  } bk_stat_t;

endpackage

// ===== rtl/core/fsfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fsfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/fsfr_cmd_queue.sv =====
// Short command queue between the request front end and the filter back end.
module fsfr_cmd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsfr_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output fsfr_pkg::cmd_t  dout,
  output logic            empty
);

  fsfr_pkg::cmd_t                    mem_r [fsfr_pkg::CMDQ_DEPTH];
  logic [fsfr_pkg::CMDQ_PTR_W-1:0]   wptr_r, rptr_r;
  logic [fsfr_pkg::CMDQ_CNT_W-1:0]   cnt_r;
  logic                              do_push, do_pop;

  assign full    = cnt_r == fsfr_pkg::CMDQ_CNT_W'(fsfr_pkg::CMDQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign dout    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == fsfr_pkg::CMDQ_PTR_W'(fsfr_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : wptr_r + fsfr_pkg::CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == fsfr_pkg::CMDQ_PTR_W'(fsfr_pkg::CMDQ_DEPTH - 1)) ?
                  '0 : rptr_r + fsfr_pkg::CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + fsfr_pkg::CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - fsfr_pkg::CMDQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

endmodule

// ===== rtl/core/fsfr_front.sv =====
// Request front end: takes requests, drops ignored ones, queues commands.
module fsfr_front (
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          req_type,
  input  logic signed [fsfr_pkg::SAMPLE_BITS-1:0] sample_in,
  input  logic                                first_channel,
  input  logic [fsfr_pkg::IDX_W-1:0]          coef_index,
  input  logic signed [fsfr_pkg::COEF_BITS-1:0]   coef_value,
  input  logic                                cap_en,
  input  logic                                q_full,
  output logic                                q_push,
  output fsfr_pkg::cmd_t                      q_cmd
);

  logic keep;

  always_comb begin
    unique case (req_type)
      fsfr_pkg::REQ_SAMPLE: keep = cap_en && first_channel;
      fsfr_pkg::REQ_COEF:   keep = coef_index < fsfr_pkg::IDX_W'(fsfr_pkg::TAPS);
      fsfr_pkg::REQ_FLUSH:  keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign full         = q_full;
  assign q_push       = push && !q_full && keep;
  assign q_cmd.kind   = req_type;
  assign q_cmd.sample = sample_in;
  assign q_cmd.idx    = fsfr_pkg::TAP_W'(coef_index);
  assign q_cmd.coef   = coef_value;

endmodule

// ===== rtl/core/fsfr_back.sv =====
// Filter back end: delay line, phase stepping, shared MAC and result register.
module fsfr_back (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_empty,
  input  fsfr_pkg::cmd_t                          q_cmd,
  output logic                                    q_pop,
  input  logic [fsfr_pkg::STEP_W-1:0]             rate_step,
  output logic signed [fsfr_pkg::SAMPLE_BITS-1:0] sample_out,
  output logic                                    last_of_run,
  output logic                                    empty,
  input  logic                                    pop,
  output fsfr_pkg::bk_stat_t                      stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam logic signed [fsfr_pkg::PHASE_W-1:0] ONE  =
    fsfr_pkg::PHASE_W'(1 << fsfr_pkg::FRAC_BITS);
  localparam logic signed [fsfr_pkg::PHASE_W-1:0] HALF =
    fsfr_pkg::PHASE_W'(1 << (fsfr_pkg::FRAC_BITS - 1));
  localparam logic signed [fsfr_pkg::ACC_W:0] RND  =
    (fsfr_pkg::ACC_W + 1)'(1 << (fsfr_pkg::FRAC_BITS - 1));
  localparam logic signed [fsfr_pkg::ACC_W:0] SMAX =
    (fsfr_pkg::ACC_W + 1)'((1 << (fsfr_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [fsfr_pkg::ACC_W:0] SMIN =
    (fsfr_pkg::ACC_W + 1)'(-(1 << (fsfr_pkg::SAMPLE_BITS - 1)));

  logic [1:0]                              state_r, state_nxt;
  logic signed [fsfr_pkg::SAMPLE_BITS-1:0] hist_r [fsfr_pkg::TAPS];
  logic [fsfr_pkg::SEEN_W-1:0]             seen_r;
  logic signed [fsfr_pkg::PHASE_W-1:0]     phase_r;
  logic [fsfr_pkg::OCNT_W-1:0]             cnt_r;
  logic                                    iss_r, v1_r, l1_r, v2_r, l2_r, fin_r;
  logic [fsfr_pkg::TAP_W-1:0]              idx_r;
  logic signed [fsfr_pkg::SAMPLE_BITS-1:0] hq_r;
  logic signed [fsfr_pkg::PROD_W-1:0]      prod_r;
  logic signed [fsfr_pkg::ACC_W-1:0]       acc_r;
  logic signed [fsfr_pkg::SAMPLE_BITS-1:0] res_r, odata_r;
  logic [fsfr_pkg::OCNT_W-1:0]             ocnt_r;

  logic                                    cmd_go, is_sample, mac_start, step_go, idx_last;
  logic [fsfr_pkg::STEP_W-1:0]             step;
  logic [fsfr_pkg::COEF_BITS-1:0]          coef_rd;
  logic signed [fsfr_pkg::ACC_W:0]         rnd_sum, rnd_sh, sat;

  assign cmd_go    = (state_r == ST_IDLE) && !q_empty;
  assign q_pop     = cmd_go;
  assign is_sample = q_cmd.kind == fsfr_pkg::REQ_SAMPLE;
  assign mac_start = cmd_go && is_sample &&
                     (seen_r >= fsfr_pkg::SEEN_W'(fsfr_pkg::TAPS - 1));
  assign step      = (rate_step < fsfr_pkg::STEP_W'(fsfr_pkg::STEP_MIN)) ?
                     fsfr_pkg::STEP_W'(fsfr_pkg::STEP_MIN) : rate_step;
  assign step_go   = (state_r == ST_MAC) && (cnt_r < fsfr_pkg::OCNT_W'(fsfr_pkg::MAX_OUT)) &&
                     (phase_r < HALF);
  assign idx_last  = idx_r == fsfr_pkg::TAP_W'(fsfr_pkg::TAPS - 1);

  fsfr_ram #(
    .WIDTH (fsfr_pkg::COEF_BITS),
    .DEPTH (fsfr_pkg::TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cmd_go && (q_cmd.kind == fsfr_pkg::REQ_COEF)),
    .waddr (q_cmd.idx),
    .wdata (q_cmd.coef),
    .raddr (idx_r),
    .rdata (coef_rd)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (mac_start) state_nxt = ST_MAC;
      ST_MAC: begin
        if (fin_r) state_nxt = (cnt_r != '0) ? ST_WAIT : ST_IDLE;
      end
      ST_WAIT: if (ocnt_r == '0) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // delay line, oldest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fsfr_pkg::TAPS; i++) hist_r[i] <= '0;
    end else if (cmd_go && q_cmd.kind == fsfr_pkg::REQ_FLUSH) begin
      for (int i = 0; i < fsfr_pkg::TAPS; i++) hist_r[i] <= '0;
    end else if (cmd_go && is_sample) begin
      for (int i = 0; i < fsfr_pkg::TAPS - 1; i++) hist_r[i] <= hist_r[i+1];
      hist_r[fsfr_pkg::TAPS-1] <= q_cmd.sample;
    end
  end

  // fill count, phase, outputs due for this sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      phase_r <= '0;
      cnt_r   <= '0;
    end else if (cmd_go && q_cmd.kind == fsfr_pkg::REQ_FLUSH) begin
      seen_r  <= '0;
      phase_r <= '0;
    end else if (cmd_go && is_sample) begin
      cnt_r <= '0;
      if (seen_r < fsfr_pkg::SEEN_W'(fsfr_pkg::TAPS)) begin
        seen_r <= seen_r + fsfr_pkg::SEEN_W'(1);
      end else begin
        phase_r <= phase_r - ONE;
      end
    end else if (step_go) begin
      phase_r <= phase_r + fsfr_pkg::PHASE_W'(step);
      cnt_r   <= cnt_r + fsfr_pkg::OCNT_W'(1);
    end
  end

  // MAC pipeline control: issue, read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
      v1_r  <= 1'b0;
      l1_r  <= 1'b0;
      v2_r  <= 1'b0;
      l2_r  <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      if (mac_start) begin
        iss_r <= 1'b1;
      end else if (iss_r && idx_last) begin
        iss_r <= 1'b0;
      end
      v1_r  <= iss_r;
      l1_r  <= iss_r && idx_last;
      v2_r  <= v1_r;
      l2_r  <= l1_r;
      fin_r <= l2_r;
    end
  end

  // tap index holds at the last tap once the window is issued
  always_ff @(posedge clk) begin
    if (mac_start) begin
      idx_r <= '0;
      acc_r <= '0;
    end else begin
      if (iss_r && !idx_last) idx_r <= idx_r + fsfr_pkg::TAP_W'(1);
      if (v2_r) acc_r <= acc_r + fsfr_pkg::ACC_W'(prod_r);
    end
    hq_r   <= hist_r[idx_r];
    prod_r <= hq_r * $signed(coef_rd);
    if (fin_r) res_r <= sat[fsfr_pkg::SAMPLE_BITS-1:0];
  end

  // round half up, then saturate
  always_comb begin
    rnd_sum = (fsfr_pkg::ACC_W + 1)'(acc_r) + RND;
    rnd_sh  = rnd_sum >>> fsfr_pkg::FRAC_BITS;
    if (rnd_sh > SMAX) begin
      sat = SMAX;
    end else if (rnd_sh < SMIN) begin
      sat = SMIN;
    end else begin
      sat = rnd_sh;
    end
  end

  // result register: one value repeated for each output due
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
    end else if (state_r == ST_WAIT && ocnt_r == '0) begin
      ocnt_r <= cnt_r;
    end else if (pop && ocnt_r != '0) begin
      ocnt_r <= ocnt_r - fsfr_pkg::OCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && ocnt_r == '0) odata_r <= res_r;
  end

  assign empty        = ocnt_r == '0;
  assign last_of_run  = ocnt_r == fsfr_pkg::OCNT_W'(1);
  assign sample_out   = odata_r;
  assign stat.out_cnt = ocnt_r;

endmodule

// ===== rtl/core/fractional_sinc_fir_resampler.sv =====
// Top level of the fractional-rate 23-tap FIR resampler.
`include "fractional_sinc_fir_resampler_assert.svh"

// Requests enter a two-entry command queue through the front end, which drops
// samples of other channels, samples while capture is off, unknown requests and
// out-of-range coefficient writes. The back end takes one command at a time.
// Coefficient writes, flushes and samples that do not complete a window are
// handled in the idle state. A sample that does complete one runs through the
// single shared multiply-accumulate, which reads one coefficient per cycle from
// the coefficient RAM port, and passes through the wait state only when it
// makes results; up to four results, all carrying the same value, then leave
// one per cycle through the result register while pop is asserted.
// The back end waits only when that register still holds results. No clearing
// pass after reset; coefficients read undefined until written.
// Configuration: rate_step at byte address 0, capture_enable at 4.
module fractional_sinc_fir_resampler (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  output logic                                    full,
  input  logic [1:0]                              in_req_type,
  input  logic signed [fsfr_pkg::SAMPLE_BITS-1:0] in_sample_in,
  input  logic                                    in_first_channel,
  input  logic [fsfr_pkg::IDX_W-1:0]              in_coef_index,
  input  logic signed [fsfr_pkg::COEF_BITS-1:0]   in_coef_value,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [fsfr_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                    out_last_of_run,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [fsfr_pkg::ADDR_W-1:0]             paddr,
  input  logic [fsfr_pkg::DATA_W-1:0]             pwdata,
  output logic [fsfr_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready
);

  logic [fsfr_pkg::STEP_W-1:0] rate_r;
  logic                        cap_r;
  logic                        cfg_wr;
  logic                        q_full, q_push, q_pop, q_empty;
  fsfr_pkg::cmd_t              q_din, q_dout;
  fsfr_pkg::bk_stat_t          bk_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= fsfr_pkg::STEP_W'(fsfr_pkg::RATE_RESET);
      cap_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fsfr_pkg::REG_RATE: rate_r <= pwdata[fsfr_pkg::STEP_W-1:0];
        fsfr_pkg::REG_CAP:  cap_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fsfr_pkg::REG_RATE: prdata = fsfr_pkg::DATA_W'(rate_r);
      fsfr_pkg::REG_CAP:  prdata = fsfr_pkg::DATA_W'(cap_r);
      default:            prdata = '0;
    endcase
  end

  fsfr_front u_front (
    .push          (push),
    .full          (full),
    .req_type      (in_req_type),
    .sample_in     (in_sample_in),
    .first_channel (in_first_channel),
    .coef_index    (in_coef_index),
    .coef_value    (in_coef_value),
    .cap_en        (cap_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_din)
  );

  fsfr_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  fsfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_cmd       (q_dout),
    .q_pop       (q_pop),
    .rate_step   (rate_r),
    .sample_out  (out_sample_out),
    .last_of_run (out_last_of_run),
    .empty       (empty),
    .pop         (pop),
    .stat        (bk_stat)
  );

  // a run that is not finished keeps results waiting
  `FSFR_ASSERT_NEXT(a_run_continues, pop && !empty && !out_last_of_run, !empty)
  // after the last result of a run nothing is waiting
  `FSFR_ASSERT_NEXT(a_run_ends, pop && !empty && out_last_of_run, empty)
  // never more results pending than one sample can cause
  `FSFR_ASSERT_NOW(a_out_bound, !empty, bk_stat.out_cnt <= fsfr_pkg::OCNT_W'(fsfr_pkg::MAX_OUT))

endmodule
